>>> hdl/ipv6p_pkg.sv
package ipv6p_pkg;

    localparam int GROUPS   = 8;
    localparam int GW       = 16;
    localparam int GIDX_W   = $clog2(GROUPS);
    localparam int GCNT_W   = $clog2(GROUPS + 1);
    localparam int LEN_W    = 6;
    localparam int PHASE_W  = 3;
    localparam int DCNT_W   = 3;
    localparam int MAX_DIGITS = 4;

    localparam logic [PHASE_W-1:0] PH_START       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START_COLON = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HEAD_DIGITS = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HEAD_COLON  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TAIL_WAIT   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TAIL_DIGITS = 3'd5;
    localparam logic [PHASE_W-1:0] PH_HEAD_FULL   = 3'd6;
    localparam logic [PHASE_W-1:0] PH_TAIL_FULL   = 3'd7;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    typedef logic [GROUPS-1:0][GW-1:0] t_groups;

    // Completed address handed from the parser to the output stage
    typedef struct packed {
        logic              bad;
        logic [LEN_W-1:0]  len;
        logic [GCNT_W-1:0] head_cnt;
        logic [GCNT_W-1:0] tail_cnt;
    } t_fin;

    // {hit, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            t = c - CH_0;
            return {1'b1, t[3:0]};
        end
        if (c >= CH_LA && c <= CH_LF) begin
            t = c - CH_LA + 8'd10;
            return {1'b1, t[3:0]};
        end
        if (c >= CH_UA && c <= CH_UF) begin
            t = c - CH_UA + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

>>> hdl/ipv6p_parser.sv
module ipv6p_parser
    import ipv6p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    input  logic       i_eoi,
    input  logic       i_fin_load,
    output logic       o_fin_valid,
    output t_fin       o_fin,
    output t_groups    o_head,
    output t_groups    o_tail
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic [GW-1:0]      r_gval, n_gval;
    logic [GCNT_W-1:0]  r_hcnt, n_hcnt;
    logic [GCNT_W-1:0]  r_tcnt, n_tcnt;
    logic [LEN_W-1:0]   r_chars, n_chars;
    logic               r_fin_valid, n_fin_valid;
    t_fin               r_fin, n_fin;
    t_groups            r_head;
    t_groups            r_tail;

    logic [4:0]         hx;
    logic               is_hex, is_colon;
    logic [GW-1:0]      shifted;
    logic [DCNT_W-1:0]  dcnt_inc;
    logic [LEN_W-1:0]   chars_inc;
    logic               fire, bad;
    logic               wr_head, wr_tail;
    logic [GW-1:0]      wr_data;
    logic [GCNT_W:0]    total;

    assign hx        = hex_decode(i_char);
    assign is_hex    = !i_eoi && hx[4];
    assign is_colon  = !i_eoi && (i_char == CH_COLON);
    assign shifted   = {r_gval[GW-5:0], hx[3:0]};
    assign dcnt_inc  = r_dcnt + DCNT_W'(1);
    assign chars_inc = r_chars + LEN_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_dcnt  = r_dcnt;
        n_gval  = r_gval;
        n_hcnt  = r_hcnt;
        n_tcnt  = r_tcnt;
        n_chars = r_chars;
        fire    = 1'b0;
        bad     = 1'b0;
        wr_head = 1'b0;
        wr_tail = 1'b0;
        wr_data = r_gval;
        total   = '0;

        unique case (r_phase)
            PH_START: begin
                if (is_hex) begin
                    n_gval  = GW'(hx[3:0]);
                    n_dcnt  = DCNT_W'(1);
                    n_chars = chars_inc;
                    n_phase = PH_HEAD_DIGITS;
                end else if (is_colon) begin
                    n_chars = chars_inc;
                    n_phase = PH_START_COLON;
                end else begin
                    fire = 1'b1;
                    bad  = 1'b1;
                end
            end
            PH_START_COLON: begin
                if (is_colon) begin
                    n_chars = chars_inc;
                    n_phase = PH_TAIL_WAIT;
                end else begin
                    fire = 1'b1;
                    bad  = 1'b1;
                end
            end
            PH_HEAD_DIGITS: begin
                if (is_hex && r_dcnt < DCNT_W'(MAX_DIGITS)) begin
                    n_gval  = shifted;
                    n_dcnt  = dcnt_inc;
                    n_chars = chars_inc;
                    if (dcnt_inc >= DCNT_W'(MAX_DIGITS)) begin
                        wr_data = shifted;
                        wr_head = r_hcnt < GCNT_W'(GROUPS);
                        if (wr_head) n_hcnt = r_hcnt + GCNT_W'(1);
                        n_gval = '0;
                        n_dcnt = '0;
                        if (n_hcnt >= GCNT_W'(GROUPS)) fire = 1'b1;
                        else n_phase = PH_HEAD_FULL;
                    end
                end else begin
                    wr_data = r_gval;
                    wr_head = r_hcnt < GCNT_W'(GROUPS);
                    if (wr_head) n_hcnt = r_hcnt + GCNT_W'(1);
                    n_gval = '0;
                    n_dcnt = '0;
                    if (n_hcnt >= GCNT_W'(GROUPS)) begin
                        fire = 1'b1;
                    end else if (is_colon) begin
                        n_chars = chars_inc;
                        n_phase = PH_HEAD_COLON;
                    end else begin
                        fire = 1'b1;
                        bad  = 1'b1;
                    end
                end
            end
            PH_HEAD_FULL: begin
                if (is_colon) begin
                    n_chars = chars_inc;
                    n_phase = PH_HEAD_COLON;
                end else begin
                    fire = 1'b1;
                    bad  = 1'b1;
                end
            end
            PH_HEAD_COLON: begin
                if (is_colon) begin
                    n_chars = chars_inc;
                    n_phase = PH_TAIL_WAIT;
                end else if (is_hex) begin
                    n_gval  = GW'(hx[3:0]);
                    n_dcnt  = DCNT_W'(1);
                    n_chars = chars_inc;
                    n_phase = PH_HEAD_DIGITS;
                end else begin
                    fire = 1'b1;
                    bad  = 1'b1;
                end
            end
            PH_TAIL_WAIT: begin
                if (is_hex) begin
                    n_gval  = GW'(hx[3:0]);
                    n_dcnt  = DCNT_W'(1);
                    n_chars = chars_inc;
                    n_phase = PH_TAIL_DIGITS;
                end else begin
                    fire = 1'b1;
                end
            end
            PH_TAIL_DIGITS: begin
                if (is_hex && r_dcnt < DCNT_W'(MAX_DIGITS)) begin
                    n_gval  = shifted;
                    n_dcnt  = dcnt_inc;
                    n_chars = chars_inc;
                    if (dcnt_inc >= DCNT_W'(MAX_DIGITS)) begin
                        wr_data = shifted;
                        wr_tail = r_tcnt < GCNT_W'(GROUPS);
                        if (wr_tail) n_tcnt = r_tcnt + GCNT_W'(1);
                        n_gval = '0;
                        n_dcnt = '0;
                        total  = {1'b0, r_hcnt} + {1'b0, n_tcnt};
                        if (total >= (GCNT_W+1)'(GROUPS)) fire = 1'b1;
                        else n_phase = PH_TAIL_FULL;
                    end
                end else begin
                    wr_data = r_gval;
                    wr_tail = r_tcnt < GCNT_W'(GROUPS);
                    if (wr_tail) n_tcnt = r_tcnt + GCNT_W'(1);
                    n_gval = '0;
                    n_dcnt = '0;
                    total  = {1'b0, r_hcnt} + {1'b0, n_tcnt};
                    if (total >= (GCNT_W+1)'(GROUPS)) begin
                        fire = 1'b1;
                    end else if (is_colon) begin
                        n_chars = chars_inc;
                        n_phase = PH_TAIL_WAIT;
                    end else begin
                        fire = 1'b1;
                    end
                end
            end
            PH_TAIL_FULL: begin
                if (is_colon) begin
                    n_chars = chars_inc;
                    n_phase = PH_TAIL_WAIT;
                end else begin
                    fire = 1'b1;
                end
            end
            default: begin
                fire = 1'b1;
                bad  = 1'b1;
            end
        endcase

        n_fin.bad      = bad;
        n_fin.len      = n_chars;
        n_fin.head_cnt = n_hcnt;
        n_fin.tail_cnt = n_tcnt;

        // rearm for the next address; the stores keep their contents
        if (fire) begin
            n_phase = PH_START;
            n_dcnt  = '0;
            n_gval  = '0;
            n_hcnt  = '0;
            n_tcnt  = '0;
            n_chars = '0;
        end
    end

    assign n_fin_valid = (r_fin_valid && !i_fin_load) || (i_accept && fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_dcnt      <= '0;
            r_gval      <= '0;
            r_hcnt      <= '0;
            r_tcnt      <= '0;
            r_chars     <= '0;
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= n_fin_valid;
            if (i_accept) begin
                r_phase <= n_phase;
                r_dcnt  <= n_dcnt;
                r_gval  <= n_gval;
                r_hcnt  <= n_hcnt;
                r_tcnt  <= n_tcnt;
                r_chars <= n_chars;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && fire) r_fin <= n_fin;
        if (i_accept && wr_head) r_head[r_hcnt[GIDX_W-1:0]] <= wr_data;
        // newest tail group in entry 0, so the tail sits right-aligned
        if (i_accept && wr_tail) r_tail <= {r_tail[GROUPS-2:0], wr_data};
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;
    assign o_head      = r_head;
    assign o_tail      = r_tail;

endmodule

>>> hdl/ipv6p_assemble.sv
module ipv6p_assemble
    import ipv6p_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fin_valid,
    input  t_fin             i_fin,
    input  t_groups          i_head,
    input  t_groups          i_tail,
    input  logic             i_stall,
    output logic             o_fin_load,
    output logic             o_valid,
    output logic             o_status,
    output logic [LEN_W-1:0] o_consumed_length,
    output logic [63:0]      o_addr_high,
    output logic [63:0]      o_addr_low
);

    logic             r_valid;
    logic             r_status;
    logic [LEN_W-1:0] r_len;
    logic [127:0]     r_addr;
    logic [127:0]     n_addr;
    logic             load;

    assign load = i_fin_valid && (!r_valid || !i_stall);

    // group p: tail if p lies in the last tail_cnt slots, else head if written
    always_comb begin
        n_addr = '0;
        for (int p = 0; p < GROUPS; p++) begin
            if (!i_fin.bad) begin
                if ((GCNT_W+1)'(p) + {1'b0, i_fin.tail_cnt} >= (GCNT_W+1)'(GROUPS))
                    n_addr[(GROUPS-1-p)*GW +: GW] = i_tail[GROUPS-1-p];
                else if (GCNT_W'(p) < i_fin.head_cnt)
                    n_addr[(GROUPS-1-p)*GW +: GW] = i_head[p];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (load) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= i_fin.bad;
            r_len    <= i_fin.len;
            r_addr   <= n_addr;
        end
    end

    assign o_fin_load        = load;
    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_consumed_length = r_len;
    assign o_addr_high       = r_addr[127:64];
    assign o_addr_low        = r_addr[63:0];

endmodule

>>> hdl/ipv6_text_address_parser_core.sv
// IPv6 text address parser: one character beat accepted per cycle while o_stall is low.
// A finished address is registered in the parser's finish stage, then in the output register once i_stall allows.
// Throughput: one beat per cycle; a finished address waits in a one-entry
// holding stage, so input stalls only while that stage and the output are both full and i_stall is high.
// Reset: i_rst_n synchronous, active low; clears parse state and valid flags.
module ipv6_text_address_parser_core
    import ipv6p_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_char_in,
    input  logic             i_end_of_input,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_status,
    output logic [LEN_W-1:0] o_consumed_length,
    output logic [63:0]      o_addr_high,
    output logic [63:0]      o_addr_low
);

    logic    fin_valid;
    logic    fin_load;
    t_fin    fin;
    t_groups head;
    t_groups tail;
    logic    accept;

    // the stores must not change while a finished address is still unread
    assign o_stall = fin_valid && !fin_load;
    assign accept  = i_valid && !o_stall;

    ipv6p_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char      (i_char_in),
        .i_eoi       (i_end_of_input),
        .i_fin_load  (fin_load),
        .o_fin_valid (fin_valid),
        .o_fin       (fin),
        .o_head      (head),
        .o_tail      (tail)
    );

    ipv6p_assemble u_assemble (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fin_valid       (fin_valid),
        .i_fin             (fin),
        .i_head            (head),
        .i_tail            (tail),
        .i_stall           (i_stall),
        .o_fin_load        (fin_load),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_consumed_length (o_consumed_length),
        .o_addr_high       (o_addr_high),
        .o_addr_low        (o_addr_low)
    );

endmodule
